FILE: hdl/dxt_block_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// DXT block decoder assertion macros
// Shared property wrappers for the block's checker.
// ----------------------------------------------------------------------------
`ifndef DXT_BLOCK_DECODER_TOP_DEFINES_SVH
`define DXT_BLOCK_DECODER_TOP_DEFINES_SVH

// clocked property, disabled while reset is held
`define DXTBD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that is also checked during reset
`define DXTBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/dxtbd_pkg.sv
// ----------------------------------------------------------------------------
// DXT block decoder package
// Format codes, palette struct and constant-divisor helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package dxtbd_pkg;

  localparam int IN_W  = 128;
  localparam int OUT_W = 136;

  localparam logic [1:0] FMT_BC1 = 2'd0;
  localparam logic [1:0] FMT_BC2 = 2'd1;
  localparam logic [1:0] FMT_BC3 = 2'd2;

  typedef logic [3:0][31:0] pix_row_t;

  typedef struct packed {
    logic [7:0]      r0;
    logic [7:0]      g0;
    logic [7:0]      b0;
    logic [7:0]      r1;
    logic [7:0]      g1;
    logic [7:0]      b1;
    logic            c0_gt_c1;
    logic [7:0][7:0] apal;
  } pal_t;

  // v*255/31 = 8v + floor(7v/31); 7v/31 via reciprocal 265/2^13
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [7:0]  t;
    logic [15:0] p;
    t = 8'(v) * 8'd7;
    p = 16'(t) * 16'd265;
    return {v, 3'b000} + {5'b0, p[15:13]};
  endfunction

  // v*255/63 = 4v + floor(v/21)
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [1:0] q;
    if (v >= 6'd63)      q = 2'd3;
    else if (v >= 6'd42) q = 2'd2;
    else if (v >= 6'd21) q = 2'd1;
    else                 q = 2'd0;
    return {v, 2'b00} + {6'b0, q};
  endfunction

  // floor(t/3) for t < 768
  function automatic logic [7:0] div3(input logic [9:0] t);
    logic [19:0] p;
    p = 20'(t) * 20'd683;
    return p[18:11];
  endfunction

  // floor(t/7) for t < 1792
  function automatic logic [7:0] div7(input logic [10:0] t);
    logic [21:0] p;
    p = 22'(t) * 22'd2341;
    return p[21:14];
  endfunction

  // floor(t/5) for t < 1280
  function automatic logic [7:0] div5(input logic [10:0] t);
    logic [21:0] p;
    p = 22'(t) * 22'd1639;
    return p[20:13];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/dxtbd_palette.sv
// ----------------------------------------------------------------------------
// DXT palette builder
// Expands the 565 endpoints and builds the eight-entry interpolated alpha palette.
// ----------------------------------------------------------------------------
`default_nettype none

module dxtbd_palette (
  input  wire logic [63:0]   color_block,
  input  wire logic [63:0]   alpha_block,
  output dxtbd_pkg::pal_t    pal
);

  logic [15:0] c0;
  logic [15:0] c1;
  logic [7:0]  a0;
  logic [7:0]  a1;

  assign c0 = color_block[15:0];
  assign c1 = color_block[31:16];
  assign a0 = alpha_block[7:0];
  assign a1 = alpha_block[15:8];

  always_comb begin
    pal.r0       = dxtbd_pkg::expand5(c0[15:11]);
    pal.g0       = dxtbd_pkg::expand6(c0[10:5]);
    pal.b0       = dxtbd_pkg::expand5(c0[4:0]);
    pal.r1       = dxtbd_pkg::expand5(c1[15:11]);
    pal.g1       = dxtbd_pkg::expand6(c1[10:5]);
    pal.b1       = dxtbd_pkg::expand5(c1[4:0]);
    pal.c0_gt_c1 = (c0 > c1);

    pal.apal[0] = a0;
    pal.apal[1] = a1;
    if (a0 > a1) begin
      for (int i = 1; i < 7; i++) begin
        pal.apal[3'(i + 1)] = dxtbd_pkg::div7(11'(7 - i) * {3'b0, a0} +
                                              11'(i) * {3'b0, a1});
      end
    end else begin
      // six-value mode: fifths, then fixed 0 and 255
      for (int i = 1; i < 5; i++) begin
        pal.apal[3'(i + 1)] = dxtbd_pkg::div5(11'(5 - i) * {3'b0, a0} +
                                              11'(i) * {3'b0, a1});
      end
      pal.apal[6] = 8'h00;
      pal.apal[7] = 8'hff;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dxtbd_row.sv
// ----------------------------------------------------------------------------
// DXT row pixel select
// Forms the color palette midpoints and picks RGBA for four pixels of a row.
// ----------------------------------------------------------------------------
`default_nettype none

module dxtbd_row (
  input  wire logic [1:0]        fmt,
  input  wire dxtbd_pkg::pal_t   pal,
  input  wire logic [7:0]        row_cidx,
  input  wire logic [15:0]       row_anib,
  input  wire logic [11:0]       row_aidx,
  output dxtbd_pkg::pix_row_t    pixels
);

  logic            four_color;
  logic [7:0]      r2, g2, b2, r3, g3, b3, a3;
  logic [3:0][1:0] ci;
  logic [3:0][7:0] rr, gg, bb, aa;

  // BC2/BC3 always use the four-color palette
  assign four_color = (fmt == dxtbd_pkg::FMT_BC2) || (fmt == dxtbd_pkg::FMT_BC3) ||
                      pal.c0_gt_c1;

  always_comb begin
    if (four_color) begin
      r2 = dxtbd_pkg::div3({1'b0, pal.r0, 1'b0} + {2'b0, pal.r1});
      g2 = dxtbd_pkg::div3({1'b0, pal.g0, 1'b0} + {2'b0, pal.g1});
      b2 = dxtbd_pkg::div3({1'b0, pal.b0, 1'b0} + {2'b0, pal.b1});
      r3 = dxtbd_pkg::div3({2'b0, pal.r0} + {1'b0, pal.r1, 1'b0});
      g3 = dxtbd_pkg::div3({2'b0, pal.g0} + {1'b0, pal.g1, 1'b0});
      b3 = dxtbd_pkg::div3({2'b0, pal.b0} + {1'b0, pal.b1, 1'b0});
      a3 = 8'hff;
    end else begin
      // three-color mode: average, then transparent black
      r2 = 8'(({1'b0, pal.r0} + {1'b0, pal.r1}) >> 1);
      g2 = 8'(({1'b0, pal.g0} + {1'b0, pal.g1}) >> 1);
      b2 = 8'(({1'b0, pal.b0} + {1'b0, pal.b1}) >> 1);
      r3 = 8'h00;
      g3 = 8'h00;
      b3 = 8'h00;
      a3 = 8'h00;
    end
  end

  always_comb begin
    for (int x = 0; x < 4; x++) begin
      ci[x] = row_cidx[2*x +: 2];
      case (ci[x])
        2'd0:    begin rr[x] = pal.r0; gg[x] = pal.g0; bb[x] = pal.b0; end
        2'd1:    begin rr[x] = pal.r1; gg[x] = pal.g1; bb[x] = pal.b1; end
        2'd2:    begin rr[x] = r2;     gg[x] = g2;     bb[x] = b2;     end
        default: begin rr[x] = r3;     gg[x] = g3;     bb[x] = b3;     end
      endcase

      if (fmt == dxtbd_pkg::FMT_BC2) begin
        // n*255/15 == n*17: nibble replicated
        aa[x] = {row_anib[4*x +: 4], row_anib[4*x +: 4]};
      end else if (fmt == dxtbd_pkg::FMT_BC3) begin
        aa[x] = pal.apal[row_aidx[3*x +: 3]];
      end else begin
        aa[x] = (ci[x] == 2'd3) ? a3 : 8'hff;
      end

      pixels[x] = {aa[x], bb[x], gg[x], rr[x]};
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dxt_block_decoder_top.sv
// ----------------------------------------------------------------------------
// DXT block decoder top level
// Decodes one BC1/BC2/BC3 4x4 block into four rows of RGBA8 pixels.
// ----------------------------------------------------------------------------
// Each accepted block produces four result rows, top row first, one row per
// cycle while the result side takes them. With the result register free, the
// first row appears after the block passes the palette register, which loads
// at the accepting edge, and then the result register. A new block is taken in
// the same cycle its predecessor's last row moves to the result register.
// block_format is written through the cfg port; the user must write it only
// while no block is in flight, as the block itself does not enforce this.
`default_nettype none

module dxt_block_decoder_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // cfg write: block_format
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [1:0]                   cfg_data,
  // in_tdata: [63:0] color_block, [127:64] alpha_block
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [dxtbd_pkg::IN_W-1:0]   in_tdata,
  // out_tdata: [1:0] row_index, [33:2] pixel_0, [65:34] pixel_1,
  //            [97:66] pixel_2, [129:98] pixel_3, [135:130] zero
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [dxtbd_pkg::OUT_W-1:0]       out_tdata,
  output logic                              out_tlast
);

  logic [1:0]           fmt_r;

  dxtbd_pkg::pal_t      pal_in;
  dxtbd_pkg::pal_t      pal_r;
  logic [31:0]          cidx_r;
  logic [63:0]          ablk_r;
  logic                 blk_valid_r, blk_valid_nxt;
  logic [1:0]           row_r, row_nxt;

  dxtbd_pkg::pix_row_t  pixels;
  logic                 out_valid_r, out_valid_nxt;
  logic [dxtbd_pkg::OUT_W-1:0] out_data_r;
  logic                 out_last_r;

  logic                 in_acc;
  logic                 out_load;
  logic                 blk_done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= dxtbd_pkg::FMT_BC1;
    end else if (cfg_valid) begin
      fmt_r <= cfg_data;
    end
  end

  dxtbd_palette u_palette (
    .color_block (in_tdata[63:0]),
    .alpha_block (in_tdata[127:64]),
    .pal         (pal_in)
  );

  // result register loads whenever a block is held and it is empty or being drained
  assign out_load  = blk_valid_r && (!out_valid_r || out_tready);
  assign blk_done  = out_load && (row_r == 2'd3);
  assign in_tready = !blk_valid_r || blk_done;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    blk_valid_nxt = blk_valid_r;
    row_nxt       = row_r;
    if (in_acc) begin
      blk_valid_nxt = 1'b1;
      row_nxt       = 2'd0;
    end else begin
      if (blk_done) blk_valid_nxt = 1'b0;
      if (out_load) row_nxt = row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_valid_r <= 1'b0;
      row_r       <= 2'd0;
    end else begin
      blk_valid_r <= blk_valid_nxt;
      row_r       <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pal_r  <= pal_in;
      cidx_r <= in_tdata[63:32];
      ablk_r <= in_tdata[127:64];
    end
  end

  dxtbd_row u_row (
    .fmt      (fmt_r),
    .pal      (pal_r),
    .row_cidx (cidx_r[{row_r, 3'b000} +: 8]),
    .row_anib (ablk_r[{row_r, 4'b0000} +: 16]),
    .row_aidx (ablk_r[6'd16 + 6'(row_r) * 6'd12 +: 12]),
    .pixels   (pixels)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {6'b0, pixels[3], pixels[2], pixels[1], pixels[0], row_r};
      out_last_r <= (row_r == 2'd3);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

FILE: hdl/dxtbd_checker.sv
// ----------------------------------------------------------------------------
// DXT block decoder port checker
// Row ordering and result-channel checks on the top level's ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dxt_block_decoder_top_defines.svh"

module dxtbd_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [dxtbd_pkg::OUT_W-1:0] out_tdata,
  input wire logic                        out_tlast
);

  `DXTBD_ASSERT(a_last_on_row3, clk, rst_n, out_tvalid |-> (out_tlast == (out_tdata[1:0] == 2'd3)), "tlast does not match row 3")

  // rows of one block come back to back once the previous row is taken
  `DXTBD_ASSERT(a_row_next, clk, rst_n, (out_tvalid && out_tready && !out_tlast) |=> (out_tvalid && (out_tdata[1:0] == $past(out_tdata[1:0]) + 2'd1)), "row sequence broken inside a block")

  `DXTBD_ASSERT(a_row_restart, clk, rst_n, (out_tvalid && out_tready && out_tlast) |=> (!out_tvalid || (out_tdata[1:0] == 2'd0)), "new block does not start at row 0")

  `DXTBD_ASSERT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)), "stalled result changed")

  // an accepted block has a row on the result port after the palette and result registers
  `DXTBD_ASSERT(a_blk_to_row, clk, rst_n, (in_tvalid && in_tready) |-> ##2 out_tvalid, "accepted block produced no row")

endmodule

bind dxt_block_decoder_top dxtbd_checker u_dxtbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
